// ----- src/bcc_pkg.sv -----
// ----------------------------------------------------------------------------
// bcc_pkg: shared types and constants for the button click classifier
// Phase and event codes, configuration register indexes and port widths.
// ----------------------------------------------------------------------------
package bcc_pkg;

	// Width of the switch index field and the number of addressable slots.
	localparam int IDX_W      = 3;
	localparam int NUM_SLOTS  = 8;
	// Configuration port widths and register widths.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int MASK_W     = 8;
	localparam int KIND_W     = 2;

	// Reset values of the configuration registers.
	localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RST    = 16'd20;
	localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RST  = 16'd800;
	localparam logic [CFG_DATA_W-1:0] DOUBLE_WIN_RST  = 16'd300;
	localparam logic [MASK_W-1:0]     ACTIVE_HIGH_RST = 8'hFF;
	localparam logic [MASK_W-1:0]     ENABLE_RST      = 8'h00;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_DEBOUNCE = 3'd1,
		PH_PRESSED  = 3'd2,
		PH_RELEASED = 3'd3,
		PH_PRESSED2 = 3'd4,
		PH_WAIT     = 3'd5
	} phase_t;

	typedef enum logic [KIND_W-1:0] {
		EV_CLICK  = 2'd0,
		EV_DOUBLE = 2'd1,
		EV_LONG   = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE    = 3'd0,
		REG_LONG_PRESS  = 3'd1,
		REG_DOUBLE_WIN  = 3'd2,
		REG_ACTIVE_HIGH = 3'd3,
		REG_ENABLE      = 3'd4
	} cfg_reg_t;

endpackage

// ----- src/button_click_classifier_core.sv -----
// ----------------------------------------------------------------------------
// button_click_classifier_core: debounce and click/double/long classifier
// The input register holds each transferred item; its event, if any, then
// moves to the output register. Throughput: one item per cycle unless an
// event waits on a full output register, set by the single read-modify-write
// of the per-switch phase and counter. Reset (arst_n low) sets every switch
// to idle with a zero counter and loads the default configuration at once.
// ----------------------------------------------------------------------------
module button_click_classifier_core
	import bcc_pkg::*;
#(
	parameter int SWITCHES   = 8,
	parameter int TIMER_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Tick sample channel.
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [IDX_W-1:0]      switch_index,
	input  logic                  pin_level,
	// Event channel.
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [IDX_W-1:0]      event_switch,
	output logic [KIND_W-1:0]     event_kind,
	// Configuration write channel.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// The wider of the register width and the counter width, used when a
	// period is saturated to the counter range.
	localparam int WIDE = (TIMER_BITS > CFG_DATA_W) ? TIMER_BITS : CFG_DATA_W;
	localparam logic [WIDE-1:0] TIMER_MAX = WIDE'({TIMER_BITS{1'b1}});

	// A period that does not fit the counter is saturated to its maximum.
	function automatic logic [TIMER_BITS-1:0] clamp_period(input logic [CFG_DATA_W-1:0] p);
		logic [WIDE-1:0] pw;
		pw = WIDE'(p);
		if (pw > TIMER_MAX) begin
			pw = TIMER_MAX;
		end
		return pw[TIMER_BITS-1:0];
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers, always ready. Writes are to be made only while
	// the block is idle; the user must see to this, as it is not enforced.
	// ------------------------------------------------------------------
	logic [CFG_DATA_W-1:0] debounce_q;
	logic [CFG_DATA_W-1:0] long_press_q;
	logic [CFG_DATA_W-1:0] double_win_q;
	logic [MASK_W-1:0]     active_high_q;
	logic [MASK_W-1:0]     enable_q;
	logic                  cfg_we;
	logic                  enable_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign enable_we = cfg_we && (cfg_index == REG_ENABLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q    <= DEBOUNCE_RST;
			long_press_q  <= LONG_PRESS_RST;
			double_win_q  <= DOUBLE_WIN_RST;
			active_high_q <= ACTIVE_HIGH_RST;
			enable_q      <= ENABLE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE:    debounce_q    <= cfg_data;
				REG_LONG_PRESS:  long_press_q  <= cfg_data;
				REG_DOUBLE_WIN:  double_win_q  <= cfg_data;
				REG_ACTIVE_HIGH: active_high_q <= cfg_data[MASK_W-1:0];
				REG_ENABLE:      enable_q      <= cfg_data[MASK_W-1:0];
				default:         ;
			endcase
		end
	end

	// A slot takes part only if its enable bit is set and the switch exists.
	logic [NUM_SLOTS-1:0] slot_en;
	always_comb begin
		for (int s = 0; s < NUM_SLOTS; s++) begin
			slot_en[s] = enable_q[s] && (s < SWITCHES);
		end
	end

	// ------------------------------------------------------------------
	// Input register. It holds one tick sample while its phase update is
	// worked out; the sample moves on once its event (if any) has a place
	// in the output register.
	// ------------------------------------------------------------------
	logic             valid_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             level_s1;
	logic             advance;
	logic             in_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			idx_s1   <= switch_index;
			level_s1 <= pin_level;
		end
	end

	// ------------------------------------------------------------------
	// Per-switch state: phase and one-shot down counter, one entry per
	// addressable slot, read and written at the index of the held sample.
	// ------------------------------------------------------------------
	phase_t                phase_q [NUM_SLOTS];
	logic [TIMER_BITS-1:0] ticks_q [NUM_SLOTS];

	phase_t                cur_phase;
	logic [TIMER_BITS-1:0] cur_ticks;
	logic [TIMER_BITS-1:0] dec_ticks;
	logic                  active;
	logic                  expired;
	logic                  in_range;
	phase_t                nxt_phase;
	logic [TIMER_BITS-1:0] nxt_ticks;
	logic                  emit;
	kind_t                 kind;

	assign cur_phase = phase_q[idx_s1];
	assign cur_ticks = ticks_q[idx_s1];
	// Every sample for a switch first counts a nonzero counter down; the
	// counter has expired once it reads zero after that step.
	assign dec_ticks = (cur_ticks == '0) ? '0 : cur_ticks - TIMER_BITS'(1);
	assign expired   = (dec_ticks == '0);
	assign active    = (level_s1 == active_high_q[idx_s1]);
	assign in_range  = (32'(idx_s1) < SWITCHES);

	always_comb begin
		nxt_phase = cur_phase;
		nxt_ticks = dec_ticks;
		emit      = 1'b0;
		kind      = EV_CLICK;
		if (!slot_en[idx_s1]) begin
			// A disabled switch is held idle and stays silent.
			nxt_phase = PH_IDLE;
			nxt_ticks = '0;
		end else begin
			case (cur_phase)
				PH_DEBOUNCE: begin
					if (!active) begin
						nxt_ticks = '0;
						nxt_phase = PH_IDLE;
					end else if (expired) begin
						nxt_ticks = clamp_period(long_press_q);
						nxt_phase = PH_PRESSED;
					end
				end
				PH_PRESSED: begin
					if (!active) begin
						nxt_ticks = clamp_period(double_win_q);
						nxt_phase = PH_RELEASED;
					end else if (expired) begin
						emit      = 1'b1;
						kind      = EV_LONG;
						nxt_phase = PH_WAIT;
					end
				end
				PH_RELEASED: begin
					if (active) begin
						nxt_ticks = clamp_period(long_press_q);
						nxt_phase = PH_PRESSED2;
					end else if (expired) begin
						emit      = 1'b1;
						kind      = EV_CLICK;
						nxt_phase = PH_IDLE;
					end
				end
				PH_PRESSED2: begin
					if (!active) begin
						emit      = 1'b1;
						kind      = EV_DOUBLE;
						nxt_phase = PH_IDLE;
					end else if (expired) begin
						emit      = 1'b1;
						kind      = EV_LONG;
						nxt_phase = PH_WAIT;
					end
				end
				PH_WAIT: begin
					if (!active) begin
						nxt_phase = PH_IDLE;
					end
				end
				default: begin
					// Idle, and any code that names no phase.
					if (active) begin
						nxt_ticks = clamp_period(debounce_q);
						nxt_phase = PH_DEBOUNCE;
					end else begin
						nxt_phase = PH_IDLE;
					end
				end
			endcase
		end
	end

	// The held sample retires unless it carries an event and the output
	// register is full and not being drained this cycle.
	assign advance = valid_s1 && (!emit || !out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SLOTS; s++) begin
				phase_q[s] <= PH_IDLE;
				ticks_q[s] <= '0;
			end
		end else if (enable_we) begin
			// Writing the enable mask returns every disabled switch to idle.
			for (int s = 0; s < NUM_SLOTS; s++) begin
				if (!cfg_data[s]) begin
					phase_q[s] <= PH_IDLE;
					ticks_q[s] <= '0;
				end
			end
		end else if (advance && in_range) begin
			phase_q[idx_s1] <= nxt_phase;
			ticks_q[idx_s1] <= nxt_ticks;
		end
	end

	// ------------------------------------------------------------------
	// Output register. It holds one event until the downstream side takes
	// the transfer; samples without an event keep passing the input register.
	// ------------------------------------------------------------------
	logic             out_valid_q;
	logic [IDX_W-1:0] out_switch_q;
	kind_t            out_kind_q;
	logic             fire;

	assign fire = advance && emit && in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_switch_q <= idx_s1;
			out_kind_q   <= kind;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_switch = out_switch_q;
	assign event_kind   = out_kind_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------

	// A switch that is switched off must always read as idle.
	a_disabled_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !slot_en[idx_s1] |-> (cur_phase == PH_IDLE))
		else $error("disabled switch not idle");

	// A long click only comes from a held press.
	a_long_source: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && emit && (kind == EV_LONG)
		|-> (cur_phase == PH_PRESSED) || (cur_phase == PH_PRESSED2))
		else $error("long click from wrong phase");

	// A stalled sample stays in the input register unchanged.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(idx_s1) && $stable(level_s1))
		else $error("stalled sample lost");

	// An event waiting for the downstream side is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !fire)
		else $error("pending event overwritten");

endmodule
